[design/vdit_pkg.sv]
// vdit_pkg: shared types, sizes and the float equality function for the
// vertex deduplication table. No dependencies.
`default_nettype none

package vdit_pkg;

	// table size and derived widths
	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// fixed widths of the result fields
	localparam int VIDX_W = 10;
	localparam int UCNT_W = 11;

	// one stored vertex: eight single precision bit patterns
	typedef struct packed {
		logic [31:0] tex_v;
		logic [31:0] tex_u;
		logic [31:0] norm_z;
		logic [31:0] norm_y;
		logic [31:0] norm_x;
		logic [31:0] pos_z;
		logic [31:0] pos_y;
		logic [31:0] pos_x;
	} vertex_t;

	localparam int VERTEX_W = $bits(vertex_t);

	localparam logic [30:0] EXP_ALL_ONES = 31'h7F80_0000;

	// ieee single equality: signed zeros equal, nan equals nothing
	function automatic logic feq(input logic [31:0] a, input logic [31:0] b);
		logic [30:0] ma;
		logic [30:0] mb;
		logic        res;
		ma = a[30:0];
		mb = b[30:0];
		if (ma > EXP_ALL_ONES || mb > EXP_ALL_ONES) begin
			res = 1'b0;
		end else if (ma == 31'd0 && mb == 31'd0) begin
			res = 1'b1;
		end else begin
			res = (a == b);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

[design/vdit_ram.sv]
// vdit_ram: generic single write, single read synchronous memory with
// registered read data. No dependencies.
`default_nettype none

module vdit_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 256
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire  [$clog2(DEPTH)-1:0]  waddr,
	input  wire  [WIDTH-1:0]          wdata,
	input  wire                       re,
	input  wire  [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/vdit_match.sv]
// vdit_match: compares a stored vertex with the incoming corner, all eight
// attributes under float equality. Depends on vdit_pkg.
`default_nettype none

module vdit_match (
	input  wire vdit_pkg::vertex_t stored,
	input  wire vdit_pkg::vertex_t corner,
	output logic                   hit
);

	import vdit_pkg::*;

	// all attributes must compare equal
	always_comb begin
		hit = feq(stored.pos_x,  corner.pos_x)  &
		      feq(stored.pos_y,  corner.pos_y)  &
		      feq(stored.pos_z,  corner.pos_z)  &
		      feq(stored.norm_x, corner.norm_x) &
		      feq(stored.norm_y, corner.norm_y) &
		      feq(stored.norm_z, corner.norm_z) &
		      feq(stored.tex_u,  corner.tex_u)  &
		      feq(stored.tex_v,  corner.tex_v);
	end

endmodule

`default_nettype wire

[design/vertex_dedup_index_table_top.sv]
// vertex_dedup_index_table_top: mesh corner deduplication by linear search
// over one vertex memory. Depends on vdit_pkg, vdit_ram and vdit_match.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   in      | in_valid / in_ready | cmd, pos_xyz, norm_xyz, tex_u, tex_v
//   out     | out_valid/out_ready | vert_idx, is_new, overflow,
//           |                     | unique_count
//
// One corner at a time. A lookup reads one stored vertex per cycle from the
// memory read port, stopping at the first matching entry, or after the last
// stored entry on a miss; a clear or a lookup on an empty table goes straight
// to the result. Reset empties the table at once (count to zero), with no
// pass over the memory. A new item is taken while the last result still
// waits; the search stalls only at its end if the result register is full.
`default_nettype none

module vertex_dedup_index_table_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire                              cmd,
	input  wire  [31:0]                      pos_x,
	input  wire  [31:0]                      pos_y,
	input  wire  [31:0]                      pos_z,
	input  wire  [31:0]                      norm_x,
	input  wire  [31:0]                      norm_y,
	input  wire  [31:0]                      norm_z,
	input  wire  [31:0]                      tex_u,
	input  wire  [31:0]                      tex_v,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [vdit_pkg::VIDX_W-1:0]      vert_idx,
	output logic                             is_new,
	output logic                             overflow,
	output logic [vdit_pkg::UCNT_W-1:0]      unique_count
);

	import vdit_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		RES_CLEAR,
		RES_HIT,
		RES_MISS
	} res_kind_t;

	localparam int IDXW_W = IDX_W + VIDX_W;
	localparam int CNTW_W = CNT_W + UCNT_W;

	state_t            state_q;
	res_kind_t         kind_q;
	logic [IDX_W-1:0]  rd_ptr_q;
	logic              issue_q;
	logic              rd_vld_s1;
	logic              rd_last_s1;
	logic [IDX_W-1:0]  addr_s1;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	vertex_t           corner_q;

	vertex_t           corner_in;
	vertex_t           ram_rdata;
	logic              ram_re;
	logic              ram_we;
	logic              hit;
	logic              in_fire;
	logic              out_free;
	logic              finish_fire;
	logic              table_full;
	logic              ptr_is_last;
	logic [IDX_W-1:0]  res_idx;
	logic [CNT_W-1:0]  res_cnt;
	logic [IDXW_W-1:0] idx_wide;
	logic [CNTW_W-1:0] cnt_wide;

	// incoming corner as one vertex
	always_comb begin
		corner_in.pos_x  = pos_x;
		corner_in.pos_y  = pos_y;
		corner_in.pos_z  = pos_z;
		corner_in.norm_x = norm_x;
		corner_in.norm_y = norm_y;
		corner_in.norm_z = norm_z;
		corner_in.tex_u  = tex_u;
		corner_in.tex_v  = tex_v;
	end

	// handshake and control terms
	assign in_ready    = (state_q == ST_IDLE);
	assign in_fire     = in_valid & in_ready;
	assign out_free    = ~out_valid_q | out_ready;
	assign finish_fire = (state_q == ST_FINISH) & out_free;
	assign table_full  = (count_q == CNT_W'(TABLE_DEPTH));
	assign ptr_is_last = (CNT_W'(rd_ptr_q) == count_q - CNT_W'(1));
	assign ram_re      = (state_q == ST_SCAN) & issue_q;
	assign ram_we      = finish_fire & (kind_q == RES_MISS) & ~table_full;

	// vertex memory
	vdit_ram #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH(VERTEX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(corner_q),
		.re   (ram_re),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

	// attribute compare on the returned entry
	vdit_match u_match (
		.stored(ram_rdata),
		.corner(corner_q),
		.hit   (hit)
	);

	// sequencer: search, then result and table update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= RES_CLEAR;
			rd_ptr_q    <= '0;
			issue_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			addr_s1     <= '0;
			hit_idx_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (cmd) begin
							kind_q  <= RES_CLEAR;
							state_q <= ST_FINISH;
						end else if (count_q == '0) begin
							kind_q  <= RES_MISS;
							state_q <= ST_FINISH;
						end else begin
							rd_ptr_q <= '0;
							issue_q  <= 1'b1;
							state_q  <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_vld_s1  <= issue_q;
					rd_last_s1 <= issue_q & ptr_is_last;
					addr_s1    <= rd_ptr_q;
					if (issue_q) begin
						rd_ptr_q <= rd_ptr_q + IDX_W'(1);
						if (ptr_is_last) begin
							issue_q <= 1'b0;
						end
					end
					if (rd_vld_s1 && hit) begin
						kind_q    <= RES_HIT;
						hit_idx_q <= addr_s1;
						issue_q   <= 1'b0;
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_FINISH;
					end else if (rd_vld_s1 && rd_last_s1) begin
						kind_q    <= RES_MISS;
						issue_q   <= 1'b0;
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (kind_q == RES_CLEAR) begin
							count_q <= '0;
						end else if (kind_q == RES_MISS && !table_full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// held corner
	always_ff @(posedge clk) begin
		if (in_fire) begin
			corner_q <= corner_in;
		end
	end

	// result values for the finishing item
	always_comb begin
		res_idx = '0;
		res_cnt = count_q;
		case (kind_q)
			RES_CLEAR: begin
				res_cnt = '0;
			end
			RES_HIT: begin
				res_idx = hit_idx_q;
			end
			RES_MISS: begin
				if (!table_full) begin
					res_idx = count_q[IDX_W-1:0];
					res_cnt = count_q + CNT_W'(1);
				end
			end
			default: begin
				res_idx = '0;
			end
		endcase
		idx_wide = IDXW_W'(res_idx);
		cnt_wide = CNTW_W'(res_cnt);
	end

	// result register
	always_ff @(posedge clk) begin
		if (finish_fire) begin
			vert_idx     <= idx_wide[VIDX_W-1:0];
			unique_count <= cnt_wide[UCNT_W-1:0];
			is_new       <= (kind_q == RES_MISS) & ~table_full;
			overflow     <= (kind_q == RES_MISS) & table_full;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[tb/vdit_tb_pkg.sv]
// vdit_tb_pkg: command codes shared by the testbench top and the result checker
// of the vertex deduplication table. No dependencies.
`timescale 1ns / 100ps

package vdit_tb_pkg;

	// what one input item asks of the table
	typedef enum logic {
		CMD_LOOKUP = 1'b0,
		CMD_CLEAR  = 1'b1
	} corner_cmd_t;

endpackage

[tb/vdit_checker.sv]
// vdit_checker: watches both channels of the vertex deduplication table, keeps its
// own copy of the unique vertex table and compares every result item field by field.
// Depends on vdit_pkg and vdit_tb_pkg.
`timescale 1ns / 100ps

module vdit_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        cmd,
	input  logic [31:0]                 pos_x,
	input  logic [31:0]                 pos_y,
	input  logic [31:0]                 pos_z,
	input  logic [31:0]                 norm_x,
	input  logic [31:0]                 norm_y,
	input  logic [31:0]                 norm_z,
	input  logic [31:0]                 tex_u,
	input  logic [31:0]                 tex_v,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [vdit_pkg::VIDX_W-1:0] vert_idx,
	input  logic                        is_new,
	input  logic                        overflow,
	input  logic [vdit_pkg::UCNT_W-1:0] unique_count,
	output int                          pending,
	output int                          fail_count
);

	import vdit_pkg::*;
	import vdit_tb_pkg::*;

	typedef struct packed {
		logic [VIDX_W-1:0] vert_idx;
		logic              is_new;
		logic              overflow;
		logic [UCNT_W-1:0] unique_count;
	} lookup_result_t;

	// shadow of the unique vertex table
	vertex_t        unique_vertices [TABLE_DEPTH];
	int unsigned    unique_total;
	lookup_result_t awaited_results [$];

	// float compare on bit patterns: both zeros alike, a nan never equal
	function automatic bit float_same(input logic [31:0] a, input logic [31:0] b);
		bit a_nan;
		bit b_nan;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		if (a_nan || b_nan)
			return 1'b0;
		if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
			return 1'b1;
		return a == b;
	endfunction

	function automatic bit same_vertex(input vertex_t a, input vertex_t b);
		return float_same(a.pos_x, b.pos_x) && float_same(a.pos_y, b.pos_y) &&
			float_same(a.pos_z, b.pos_z) && float_same(a.norm_x, b.norm_x) &&
			float_same(a.norm_y, b.norm_y) && float_same(a.norm_z, b.norm_z) &&
			float_same(a.tex_u, b.tex_u) && float_same(a.tex_v, b.tex_v);
	endfunction

	// clear empties the shadow; else first match in insertion order, else append, else report a full table
	function automatic lookup_result_t resolve_corner(input logic clear_req,
		input vertex_t corner);
		lookup_result_t res;
		int unsigned    k;
		int unsigned    slot;
		bit             hit;
		res  = '0;
		hit  = 1'b0;
		slot = 0;
		if (clear_req) begin
			unique_total = 0;
			return res;
		end
		for (k = 0; k < unique_total; k++) begin
			if (!hit && same_vertex(unique_vertices[k], corner)) begin
				hit  = 1'b1;
				slot = k;
			end
		end
		if (hit) begin
			res.vert_idx = VIDX_W'(slot);
		end else if (unique_total >= TABLE_DEPTH) begin
			res.overflow = 1'b1;
		end else begin
			unique_vertices[unique_total] = corner;
			res.vert_idx = VIDX_W'(unique_total);
			res.is_new   = 1'b1;
			unique_total++;
		end
		res.unique_count = UCNT_W'(unique_total);
		return res;
	endfunction

	// predict on every accepted corner, compare on every accepted result
	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		vertex_t        corner;
		if (!arst_n) begin
			unique_total = 0;
			fail_count   = 0;
			awaited_results.delete();
			pending <= 0;
		end else begin
			if (in_valid && in_ready) begin
				corner = {tex_v, tex_u, norm_z, norm_y, norm_x, pos_z, pos_y, pos_x};
				awaited_results.push_back(resolve_corner(cmd == CMD_CLEAR, corner));
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result item with nothing awaited: vert_idx %0d", vert_idx);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (vert_idx !== want.vert_idx) begin
						$error("vert_idx: expected %0d, got %0d",
							want.vert_idx, vert_idx);
						fail_count++;
					end
					if (is_new !== want.is_new) begin
						$error("is_new: expected %0d, got %0d", want.is_new, is_new);
						fail_count++;
					end
					if (overflow !== want.overflow) begin
						$error("overflow: expected %0d, got %0d", want.overflow, overflow);
						fail_count++;
					end
					if (unique_count !== want.unique_count) begin
						$error("unique_count: expected %0d, got %0d",
							want.unique_count, unique_count);
						fail_count++;
					end
				end
			end
			pending <= awaited_results.size();
		end
	end

endmodule

[tb/tb.sv]
// tb: stimulus and verdict for the vertex deduplication table; the checker beside
// the block does all prediction. Depends on vdit_pkg, vdit_tb_pkg and vdit_checker.
`timescale 1ns / 100ps

module tb;

	import vdit_pkg::*;
	import vdit_tb_pkg::*;

	localparam int RANDOM_ITEMS = 580;
	localparam int CYCLE_LIMIT  = 12_000_000;

	// float bit patterns of interest
	localparam logic [31:0] POS_ZERO   = 32'h0000_0000;
	localparam logic [31:0] NEG_ZERO   = 32'h8000_0000;
	localparam logic [31:0] PLUS_ONE   = 32'h3F80_0000;
	localparam logic [31:0] MINUS_ONE  = 32'hBF80_0000;
	localparam logic [31:0] POS_INF    = 32'h7F80_0000;
	localparam logic [31:0] NEG_INF    = 32'hFF80_0000;
	localparam logic [31:0] QUIET_NAN  = 32'h7FC0_0000;
	localparam logic [31:0] SIGNAL_NAN = 32'h7F80_0001;
	localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
	localparam logic [31:0] MIN_DENORM = 32'h0000_0001;
	localparam logic [31:0] PLUS_TWO   = 32'h4000_0000;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic                cmd          = CMD_LOOKUP;
	logic [31:0]         pos_x        = '0;
	logic [31:0]         pos_y        = '0;
	logic [31:0]         pos_z        = '0;
	logic [31:0]         norm_x       = '0;
	logic [31:0]         norm_y       = '0;
	logic [31:0]         norm_z       = '0;
	logic [31:0]         tex_u        = '0;
	logic [31:0]         tex_v        = '0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [VIDX_W-1:0]   vert_idx;
	logic                is_new;
	logic                overflow;
	logic [UCNT_W-1:0]   unique_count;
	int                  pending;
	int                  fail_count;

	int                  cycle_count  = 0;
	bit                  sender_burst = 1'b0;
	bit                  sink_burst   = 1'b0;
	vertex_t             sent_corners [$];

	vertex_dedup_index_table_top u_top (.*);

	vdit_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop if results never drain
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// result side: random stall per item, with stretches of none
	initial begin
		int stall;
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 24) == 0)
				sink_burst = !sink_burst;
			stall = sink_burst ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// mostly plain random words, sometimes a float of interest
	function automatic logic [31:0] pick_word();
		logic [31:0] w;
		w = $urandom();
		if ($urandom_range(0, 99) < 35) begin
			case ($urandom_range(0, 9))
				0: w = POS_ZERO;
				1: w = NEG_ZERO;
				2: w = PLUS_ONE;
				3: w = MINUS_ONE;
				4: w = POS_INF;
				5: w = NEG_INF;
				6: w = QUIET_NAN;
				7: w = SIGNAL_NAN;
				8: w = ALL_ONES;
				default: w = MIN_DENORM;
			endcase
		end
		return w;
	endfunction

	function automatic vertex_t random_corner();
		logic [7:0][31:0] words;
		int               k;
		for (k = 0; k < 8; k++)
			words[k] = pick_word();
		return words;
	endfunction

	// same corner, with the sign of any zero field flipped at random
	function automatic vertex_t signed_zero_twin(input vertex_t v);
		logic [7:0][31:0] words;
		int               k;
		words = v;
		for (k = 0; k < 8; k++) begin
			if (words[k][30:0] == 31'd0 && $urandom_range(0, 1) == 1)
				words[k][31] = ~words[k][31];
		end
		return words;
	endfunction

	// one item on the input channel, held until taken
	task automatic drive_item(input corner_cmd_t op, input vertex_t v);
		int gap;
		if ($urandom_range(0, 19) == 0)
			sender_burst = !sender_burst;
		gap = sender_burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		pos_x    <= v.pos_x;
		pos_y    <= v.pos_y;
		pos_z    <= v.pos_z;
		norm_x   <= v.norm_x;
		norm_y   <= v.norm_y;
		norm_z   <= v.norm_z;
		tex_u    <= v.tex_u;
		tex_v    <= v.tex_v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_corner(input vertex_t v);
		drive_item(CMD_LOOKUP, v);
		sent_corners.push_back(v);
	endtask

	task automatic send_clear(input vertex_t junk);
		drive_item(CMD_CLEAR, junk);
		sent_corners.delete();
	endtask

	// hold the sender off until every awaited result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		vertex_t          c;
		vertex_t          first_fill;
		vertex_t          mid_fill;
		vertex_t          last_fill;
		logic [7:0][31:0] words;
		int               n;
		int               pick;
		int               seg_cap;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zeros of both signs, nans, infinities, one-bit misses, clears
		send_clear({8{ALL_ONES}});
		send_corner({8{POS_ZERO}});
		send_corner({8{NEG_ZERO}});
		send_corner({4{NEG_ZERO, POS_ZERO}});
		send_corner({8{ALL_ONES}});
		send_corner({8{ALL_ONES}});
		send_corner({8{POS_INF}});
		send_corner({8{POS_INF}});
		send_corner({8{NEG_INF}});
		send_corner({SIGNAL_NAN, {7{PLUS_ONE}}});
		send_corner({SIGNAL_NAN, {7{PLUS_ONE}}});
		c = {4{32'hAAAA_AAAA, 32'h5555_5555}};
		send_corner(c);
		c.tex_v = c.tex_v ^ 32'h1;
		send_corner(c);
		send_corner({4{32'hAAAA_AAAA, 32'h5555_5555}});
		send_corner({{7{POS_ZERO}}, QUIET_NAN});
		send_corner({8{MIN_DENORM}});
		send_clear({8{POS_ZERO}});
		send_corner({8{POS_ZERO}});

		// fill every slot with distinct corners: pos_x is the slot number,
		// the rest random but never nan
		send_clear(random_corner());
		for (n = 0; n < TABLE_DEPTH; n++) begin
			c = random_corner();
			words = c;
			for (pick = 0; pick < 8; pick++)
				words[pick][30] = 1'b0;
			c = words;
			c.pos_x = 32'(n);
			if (n == 0)
				first_fill = c;
			if (n == TABLE_DEPTH / 2)
				mid_fill = c;
			if (n == TABLE_DEPTH - 1)
				last_fill = c;
			drive_item(CMD_LOOKUP, c);
		end

		// full table: hits at both ends and the middle, then misses overflow
		drain_results();
		send_corner(last_fill);
		c = first_fill;
		c.pos_x = NEG_ZERO;
		send_corner(c);
		send_corner(mid_fill);
		c = random_corner();
		c.pos_x = PLUS_TWO;
		send_corner(c);
		send_corner({8{ALL_ONES}});
		send_clear(random_corner());

		// random: short table lifetimes, mostly repeats and near misses
		seg_cap = $urandom_range(2, 64);
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick == 0)
				drain_results();
			if (sent_corners.size() >= seg_cap || pick < 3) begin
				send_clear(random_corner());
				seg_cap = $urandom_range(2, 64);
			end else if (pick < 50 && sent_corners.size() != 0) begin
				c = sent_corners[$urandom_range(0, sent_corners.size() - 1)];
				send_corner(signed_zero_twin(c));
			end else if (pick < 62 && sent_corners.size() != 0) begin
				words = sent_corners[$urandom_range(0, sent_corners.size() - 1)];
				words[$urandom_range(0, 7)] = pick_word();
				send_corner(words);
			end else begin
				send_corner(random_corner());
			end
		end

		// let the last results come back, then a short quiet spell
		drain_results();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[sim.f]
design/vdit_pkg.sv
design/vdit_ram.sv
design/vdit_match.sv
design/vertex_dedup_index_table_top.sv
tb/vdit_tb_pkg.sv
tb/vdit_checker.sv
tb/tb.sv
